@@ src/fvc_pkg.sv @@
// ----------------------------------------------------------------------------
// fvc_pkg
// shared constants, types and the angle table of the flow color pipeline
// ----------------------------------------------------------------------------
package fvc_pkg;

    localparam int PRESHIFT     = 20;
    localparam int CORDIC_STEPS = 16;
    localparam int ZW           = 20;      // signed angle accumulator width
    localparam int QUARTER_TURN = 98304;   // angle units per quarter turn
    localparam int HUE_BITS     = 11;      // 0..1535, 256 per sector
    localparam int SAT_BITS     = 11;      // q1.10, 0..1024
    localparam int SAT_FRAC     = 10;
    localparam int SAT_ONE      = 1024;
    localparam int VW           = 19;      // q1.18 color value width
    localparam int ONE_Q18      = 262144;
    localparam int MAXM_BITS    = 16;
    localparam int MAXM_RESET   = 800;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    // arctangent of 2^-i in units of 393216 per turn
    function automatic logic [15:0] atan_step(input int i);
        logic [15:0] v;
        unique case (i)
            0:  v = 16'd49152;
            1:  v = 16'd29016;
            2:  v = 16'd15331;
            3:  v = 16'd7782;
            4:  v = 16'd3906;
            5:  v = 16'd1955;
            6:  v = 16'd978;
            7:  v = 16'd489;
            8:  v = 16'd244;
            9:  v = 16'd122;
            10: v = 16'd61;
            11: v = 16'd31;
            12: v = 16'd15;
            13: v = 16'd8;
            14: v = 16'd4;
            15: v = 16'd2;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

@@ src/fvc_cordic.sv @@
// ----------------------------------------------------------------------------
// fvc_cordic
// quadrant fold and sixteen cordic vectoring stages giving the hue
// ----------------------------------------------------------------------------
module fvc_cordic #(
    parameter int FB = 16,
    parameter int SW = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [FB-1:0]                i_x,
    input  logic signed [FB-1:0]                i_y,
    input  logic [SW-1:0]                       i_side,
    output logic                                o_valid,
    output logic [fvc_pkg::HUE_BITS-1:0]        o_hue,
    output logic [SW-1:0]                       o_side
);
    import fvc_pkg::*;

    localparam int CW = FB + PRESHIFT + 3;
    localparam int NS = CORDIC_STEPS;

    logic signed [CW-1:0] xe, ye, fa, fb;
    logic [1:0]           fq;

    logic signed [CW-1:0] r_a [0:NS];
    logic signed [CW-1:0] r_b [0:NS];
    logic signed [ZW-1:0] r_z [0:NS];
    logic [1:0]           r_q [0:NS];
    logic [SW-1:0]        r_side [0:NS];
    logic                 r_v [0:NS];

    logic [16:0]          zc;
    logic [18:0]          hfull;
    logic                 r_ov;
    logic [HUE_BITS-1:0]  r_hue;
    logic [SW-1:0]        r_oside;

    assign xe = {{(CW-FB){i_x[FB-1]}}, i_x};
    assign ye = {{(CW-FB){i_y[FB-1]}}, i_y};

    // fold into the first quadrant by whole quarter turns
    always_comb begin
        priority if (!i_y[FB-1] && !i_x[FB-1] && (i_x != '0)) begin
            fq = 2'd0; fa = xe;  fb = ye;
        end else if ((i_x[FB-1] || i_x == '0) && !i_y[FB-1] && (i_y != '0)) begin
            fq = 2'd1; fa = ye;  fb = -xe;
        end else if (i_x[FB-1] && (i_y[FB-1] || i_y == '0)) begin
            fq = 2'd2; fa = -xe; fb = -ye;
        end else begin
            fq = 2'd3; fa = -ye; fb = xe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a[0]    <= fa <<< PRESHIFT;
            r_b[0]    <= fb <<< PRESHIFT;
            r_z[0]    <= '0;
            r_q[0]    <= fq;
            r_side[0] <= i_side;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_step
        logic signed [ZW-1:0] ang;
        assign ang = $signed({{(ZW-16){1'b0}}, atan_step(i)});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_b[i][CW-1]) begin
                    r_a[i+1] <= r_a[i] + (r_b[i] >>> i);
                    r_b[i+1] <= r_b[i] - (r_a[i] >>> i);
                    r_z[i+1] <= r_z[i] + ang;
                end else begin
                    r_a[i+1] <= r_a[i] - (r_b[i] >>> i);
                    r_b[i+1] <= r_b[i] + (r_a[i] >>> i);
                    r_z[i+1] <= r_z[i] - ang;
                end
                r_q[i+1]    <= r_q[i];
                r_side[i+1] <= r_side[i];
            end
        end
    end

    // clamp residue into one quarter turn
    always_comb begin
        priority if (r_z[NS][ZW-1]) begin
            zc = '0;
        end else if (r_z[NS] > ZW'(QUARTER_TURN - 1)) begin
            zc = 17'(QUARTER_TURN - 1);
        end else begin
            zc = r_z[NS][16:0];
        end
        hfull = 19'(r_q[NS]) * 19'(QUARTER_TURN) + 19'(zc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hue   <= hfull[18:8];
            r_oside <= r_side[NS];
        end
    end

    assign o_valid = r_ov;
    assign o_hue   = r_hue;
    assign o_side  = r_oside;

endmodule

@@ src/fvc_sqrt.sv @@
// ----------------------------------------------------------------------------
// fvc_sqrt
// integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module fvc_sqrt #(
    parameter int FB = 16,
    parameter int SW = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*FB-1:0]   i_n,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [FB-1:0]     o_root,
    output logic [SW-1:0]     o_side
);
    import fvc_pkg::*;

    localparam int RW = 2 * FB + 1;

    logic [RW-1:0] r_rem  [0:FB];
    logic [FB-1:0] r_root [0:FB];
    logic [SW-1:0] r_side [0:FB];
    logic          r_v    [0:FB];

    always_comb begin
        r_rem[0]  = RW'(i_n);
        r_root[0] = '0;
        r_side[0] = i_side;
        r_v[0]    = i_valid;
    end

    for (genvar k = 0; k < FB; k++) begin : g_bit
        localparam int B = FB - 1 - k;
        logic [RW-1:0] trial;
        // candidate increment of the square when root bit B is set
        assign trial = (RW'(r_root[k]) << (B + 1)) + (RW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[k] >= trial) begin
                    r_rem[k+1]  <= r_rem[k] - trial;
                    r_root[k+1] <= r_root[k] | (FB'(1) << B);
                end else begin
                    r_rem[k+1]  <= r_rem[k];
                    r_root[k+1] <= r_root[k];
                end
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[FB];
    assign o_root  = r_root[FB];
    assign o_side  = r_side[FB];

endmodule

@@ src/fvc_sat.sv @@
// ----------------------------------------------------------------------------
// fvc_sat
// saturation = min(1, magnitude / max), restoring division one bit per stage
// ----------------------------------------------------------------------------
module fvc_sat #(
    parameter int FB = 16,
    parameter int SW = 11
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [FB-1:0]                   i_mag,
    input  logic [fvc_pkg::MAXM_BITS-1:0]   i_maxm,
    input  logic [SW-1:0]                   i_side,
    output logic                            o_valid,
    output logic [fvc_pkg::SAT_BITS-1:0]    o_sat,
    output logic [SW-1:0]                   o_side
);
    import fvc_pkg::*;

    localparam int MW = (FB > MAXM_BITS) ? FB : MAXM_BITS;
    localparam int NQ = SAT_FRAC;

    logic [MAXM_BITS-1:0] maxm;
    logic [MAXM_BITS-1:0] r_rem  [0:NQ];
    logic [NQ-1:0]        r_quo  [0:NQ];
    logic                 r_full [0:NQ];
    logic [SW-1:0]        r_side [0:NQ];
    logic                 r_v    [0:NQ];

    // a zero maximum behaves as one
    assign maxm = (i_maxm == '0) ? MAXM_BITS'(1) : i_maxm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_full[0] <= MW'(i_mag) >= MW'(maxm);
            r_rem[0]  <= (MW'(i_mag) >= MW'(maxm)) ? '0 : MAXM_BITS'(i_mag);
            r_quo[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < NQ; k++) begin : g_div
        logic [MAXM_BITS:0] dbl;
        assign dbl = {r_rem[k], 1'b0};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (dbl >= {1'b0, maxm}) begin
                    r_rem[k+1] <= MAXM_BITS'(dbl - {1'b0, maxm});
                    r_quo[k+1] <= {r_quo[k][NQ-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= dbl[MAXM_BITS-1:0];
                    r_quo[k+1] <= {r_quo[k][NQ-2:0], 1'b0};
                end
                r_full[k+1] <= r_full[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[NQ];
    assign o_sat   = r_full[NQ] ? SAT_BITS'(SAT_ONE) : {1'b0, r_quo[NQ]};
    assign o_side  = r_side[NQ];

endmodule

@@ src/fvc_color.sv @@
// ----------------------------------------------------------------------------
// fvc_color
// six-sector hsv to rgb with value fixed at one, two stages
// ----------------------------------------------------------------------------
module fvc_color #(
    parameter int CB = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [fvc_pkg::HUE_BITS-1:0]    i_hue,
    input  logic [fvc_pkg::SAT_BITS-1:0]    i_sat,
    output logic                            o_valid,
    output logic [CB-1:0]                   o_red,
    output logic [CB-1:0]                   o_green,
    output logic [CB-1:0]                   o_blue
);
    import fvc_pkg::*;

    localparam logic [CB-1:0] FULL = {CB{1'b1}};

    function automatic logic [CB-1:0] to_channel(input logic [VW-1:0] v);
        logic [VW+CB-1:0] prod;
        prod = (VW+CB)'(v) * (VW+CB)'(FULL);
        return prod[VW+CB-2:VW-1];
    endfunction

    logic [7:0]    f;
    logic [8:0]    fc;
    logic          r_v1, r_v2;
    logic [VW-1:0] r_p, r_q, r_t;
    t_sector       r_sec;
    logic [VW-1:0] vr, vg, vb;
    logic [CB-1:0] r_red, r_green, r_blue;

    assign f  = i_hue[7:0];
    assign fc = 9'd256 - 9'(f);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= VW'(SAT_BITS'(SAT_ONE) - i_sat) << 8;
            r_q   <= VW'(ONE_Q18) - VW'(i_sat) * VW'(f);
            r_t   <= VW'(ONE_Q18) - VW'(i_sat) * VW'(fc);
            r_sec <= t_sector'(i_hue[HUE_BITS-1:8]);
        end
    end

    always_comb begin
        unique case (r_sec)
            SEC_RED_YEL: begin vr = VW'(ONE_Q18); vg = r_t; vb = r_p; end
            SEC_YEL_GRN: begin vr = r_q; vg = VW'(ONE_Q18); vb = r_p; end
            SEC_GRN_CYN: begin vr = r_p; vg = VW'(ONE_Q18); vb = r_t; end
            SEC_CYN_BLU: begin vr = r_p; vg = r_q; vb = VW'(ONE_Q18); end
            SEC_BLU_MAG: begin vr = r_t; vg = r_p; vb = VW'(ONE_Q18); end
            default:     begin vr = VW'(ONE_Q18); vg = r_p; vb = r_q; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= to_channel(vr);
            r_green <= to_channel(vg);
            r_blue  <= to_channel(vb);
        end
    end

    assign o_valid = r_v2;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

@@ src/flow_vector_to_color_unit.sv @@
// ----------------------------------------------------------------------------
// flow_vector_to_color_unit
// hsv color coding of one optical flow vector per pixel
// ----------------------------------------------------------------------------
// usage
//   slave stream: one beat per pixel, tdata = {flow_y, flow_x}, q11.4 signed
//   master stream: one beat per pixel, tdata = {blue, green, red}
//   cfg channel: writes max_magnitude, the flow length that maps to full
//     saturation; always ready, write only while no pixel is in flight
// throughput: one pixel per cycle unless stalled; every stage is a register stage
// stages: one squaring stage, 18 cordic stages for the angle, one stage per
//   root bit, 11 division stages for the saturation, two color stages
// reset: clears every stage valid bit and sets max_magnitude to 800
// stall: the whole pipeline holds while the output beat is not taken;
//   bubbles inside the pipeline hold their place and are not squeezed out
// ----------------------------------------------------------------------------
module flow_vector_to_color_unit #(
    parameter int FLOW_BITS    = 16,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // flow input
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [((2*FLOW_BITS+7)/8)*8-1:0]     i_s_tdata,    // flow_x, flow_y
    // color output
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [((3*CHANNEL_BITS+7)/8)*8-1:0]  o_m_tdata,    // red, green, blue
    // max_magnitude register write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fvc_pkg::MAXM_BITS-1:0]        i_cfg_data
);
    import fvc_pkg::*;

    localparam int FB    = FLOW_BITS;
    localparam int CB    = CHANNEL_BITS;
    localparam int OUT_W = ((3 * CB + 7) / 8) * 8;

    logic                 en;
    logic [MAXM_BITS-1:0] r_max_magnitude;

    // input squaring stage
    logic signed [FB-1:0] in_x, in_y;
    logic [FB-1:0]        abs_x, abs_y;
    logic                 r_v0;
    logic signed [FB-1:0] r_x, r_y;
    logic [2*FB-1:0]      r_sqx, r_sqy;

    // stage links
    logic                 cor_v;
    logic [HUE_BITS-1:0]  cor_hue;
    logic [2*FB-1:0]      cor_n;
    logic                 sq_v;
    logic [FB-1:0]        sq_root;
    logic [HUE_BITS-1:0]  sq_hue;
    logic                 sat_v;
    logic [SAT_BITS-1:0]  sat_s;
    logic [HUE_BITS-1:0]  sat_hue;
    logic [CB-1:0]        red, green, blue;

    // one shared advance: move whenever the output slot is free or taken
    assign en          = !o_m_tvalid || i_m_tready;
    assign o_s_tready  = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_magnitude <= MAXM_BITS'(MAXM_RESET);
        end else if (i_cfg_valid) begin
            r_max_magnitude <= i_cfg_data;
        end
    end

    assign in_x  = i_s_tdata[FB-1:0];
    assign in_y  = i_s_tdata[2*FB-1:FB];
    assign abs_x = in_x[FB-1] ? FB'(-in_x) : FB'(in_x);
    assign abs_y = in_y[FB-1] ? FB'(-in_y) : FB'(in_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x   <= in_x;
            r_y   <= in_y;
            r_sqx <= (2*FB)'(abs_x) * (2*FB)'(abs_x);
            r_sqy <= (2*FB)'(abs_y) * (2*FB)'(abs_y);
        end
    end

    // angle path; the sum of squares rides along
    fvc_cordic #(
        .FB (FB),
        .SW (2 * FB)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v0),
        .i_x     (r_x),
        .i_y     (r_y),
        .i_side  (r_sqx + r_sqy),
        .o_valid (cor_v),
        .o_hue   (cor_hue),
        .o_side  (cor_n)
    );

    // magnitude
    fvc_sqrt #(
        .FB (FB),
        .SW (HUE_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cor_v),
        .i_n     (cor_n),
        .i_side  (cor_hue),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_hue)
    );

    // saturation
    fvc_sat #(
        .FB (FB),
        .SW (HUE_BITS)
    ) u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_mag   (sq_root),
        .i_maxm  (r_max_magnitude),
        .i_side  (sq_hue),
        .o_valid (sat_v),
        .o_sat   (sat_s),
        .o_side  (sat_hue)
    );

    // hsv to rgb, last stage is the output register
    fvc_color #(
        .CB (CB)
    ) u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sat_v),
        .i_hue   (sat_hue),
        .i_sat   (sat_s),
        .o_valid (o_m_tvalid),
        .o_red   (red),
        .o_green (green),
        .o_blue  (blue)
    );

    assign o_m_tdata = OUT_W'({blue, green, red});

`ifndef ASSERT_OFF
    a_reset_empties : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_hue_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_v |-> (cor_hue < HUE_BITS'(1536)))
        else $error("hue beyond six sectors");

    a_sat_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sat_v |-> (sat_s <= SAT_BITS'(SAT_ONE)))
        else $error("saturation above one");

    a_stall_freezes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(sat_s) && $stable(cor_hue))
        else $error("pipeline moved during stall");
`endif

endmodule
